FILE: hw/rtl/gbc_pkg.sv
// shared types, constants and helpers for the gyro bias calibrator
package gbc_pkg;

	localparam int TARGET_W = 13;
	localparam int SCALE_W = 16;
	localparam int RAW_W = 16;
	localparam int ERR_W = 8;
	localparam int STATUS_W = 2;
	localparam int OFFSET_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	// fixed point shift of the offset, Q15.16 result from a Q8.8 scale
	localparam int OFFSET_SHIFT = 24;

	localparam int TARGET_CFG_MAX = (1 << TARGET_W) - 1;
	localparam int MAX_SAMPLES_DEF = 4096;
	localparam int EXTRA_ATTEMPTS_DEF = 200;

	localparam logic [TARGET_W-1:0] TARGET_RESET = 13'd1000;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd33536;

	// reciprocal of five, exact for inputs below 2^18
	localparam int DIV5_SHIFT = 18;
	localparam logic [DIV5_SHIFT-3:0] DIV5_MULT = 16'd52429;

	typedef enum logic {
		OP_START = 1'b0,
		OP_SAMPLE = 1'b1
	} opcode_t;

	typedef enum logic {
		KIND_PROGRESS = 1'b0,
		KIND_DONE = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 2'd0,
		ST_INVALID = 2'd1,
		ST_READ_ERR = 2'd2,
		ST_FAIL = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET = 1'b0,
		CFG_SCALE = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef struct packed {
		logic in_ready;
		logic load_prog;
		logic load_fin;
		logic div_start;
		logic div_store;
		axis_t axis;
	} gbc_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic prog;
		logic fin;
		logic need_div;
		logic out_busy;
		logic div_done;
	} gbc_sts_t;

	function automatic logic [TARGET_W-1:0] div5(input logic [TARGET_W-1:0] v);
		logic [TARGET_W+DIV5_SHIFT-3:0] prod;
		prod = (TARGET_W + DIV5_SHIFT - 2)'(v) * (TARGET_W + DIV5_SHIFT - 2)'(DIV5_MULT);
		return prod[DIV5_SHIFT +: TARGET_W];
	endfunction

endpackage

FILE: hw/rtl/gbc_if.sv
// handshake channel interfaces: sample items, results, register writes
interface gbc_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic read_ok;
	logic [gbc_pkg::ERR_W-1:0] read_error;
	logic signed [gbc_pkg::RAW_W-1:0] raw_x;
	logic signed [gbc_pkg::RAW_W-1:0] raw_y;
	logic signed [gbc_pkg::RAW_W-1:0] raw_z;

	modport source (output valid, opcode, read_ok, read_error, raw_x, raw_y, raw_z,
		input ready);
	modport sink (input valid, opcode, read_ok, read_error, raw_x, raw_y, raw_z,
		output ready);
endinterface

interface gbc_out_if;
	logic valid;
	logic ready;
	logic kind;
	logic [gbc_pkg::STATUS_W-1:0] status;
	logic [gbc_pkg::ERR_W-1:0] error_code;
	logic [gbc_pkg::TARGET_W-1:0] good_count;
	logic signed [gbc_pkg::OFFSET_W-1:0] offset_x;
	logic signed [gbc_pkg::OFFSET_W-1:0] offset_y;
	logic signed [gbc_pkg::OFFSET_W-1:0] offset_z;
	logic last_result;

	modport source (output valid, kind, status, error_code, good_count,
		offset_x, offset_y, offset_z, last_result, input ready);
	modport sink (input valid, kind, status, error_code, good_count,
		offset_x, offset_y, offset_z, last_result, output ready);
endinterface

interface gbc_cfg_if;
	logic valid;
	logic ready;
	logic [gbc_pkg::CFG_IDX_W-1:0] index;
	logic [gbc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/gbc_div.sv
// bit-serial restoring divider with sign handling and 32-bit saturation
module gbc_div #(
	parameter int SUM_W = 29,
	parameter int DEN_W = 29
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [SUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	output logic busy,
	output logic done,
	output logic signed [gbc_pkg::OFFSET_W-1:0] quot
);
	import gbc_pkg::*;

	localparam int NUM_W = SUM_W + OFFSET_SHIFT;
	localparam int CNT_W = $clog2(NUM_W);

	logic busy_q;
	logic done_q;
	logic neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;

	logic [SUM_W-1:0] mag;
	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic ge;
	logic hi_nz;

	assign mag = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {mag, {OFFSET_SHIFT{1'b0}}};
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[SUM_W-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	// quotient magnitude above 2^31 saturates either way
	assign hi_nz = |quo_q[NUM_W-1:OFFSET_W];

	always_comb begin
		if (neg_q) begin
			if (hi_nz || (quo_q[OFFSET_W-1] && (|quo_q[OFFSET_W-2:0])))
				quot = {1'b1, {(OFFSET_W-1){1'b0}}};
			else
				quot = OFFSET_W'(-quo_q[OFFSET_W-1:0]);
		end else begin
			if (hi_nz || quo_q[OFFSET_W-1])
				quot = {1'b0, {(OFFSET_W-1){1'b1}}};
			else
				quot = quo_q[OFFSET_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

FILE: hw/rtl/gbc_datapath.sv
// run state, per-axis sums, register file, result register and divider
module gbc_datapath #(
	parameter int MAX_SAMPLES = gbc_pkg::MAX_SAMPLES_DEF,
	parameter int EXTRA_ATTEMPTS = gbc_pkg::EXTRA_ATTEMPTS_DEF
) (
	input logic clk,
	input logic arst_n,
	gbc_in_if.sink items,
	gbc_out_if.source results,
	gbc_cfg_if.sink cfg,
	input gbc_pkg::gbc_cmd_t cmd,
	output gbc_pkg::gbc_sts_t sts
);
	import gbc_pkg::*;

	localparam int TGT_MAX = (MAX_SAMPLES < TARGET_CFG_MAX) ? MAX_SAMPLES : TARGET_CFG_MAX;
	localparam int GOOD_W = $clog2(TGT_MAX + 1);
	localparam int ATT_W = $clog2(TGT_MAX + EXTRA_ATTEMPTS + 1);
	localparam int SUM_W = $clog2(TGT_MAX) + 17;
	localparam int DEN_W = GOOD_W + SCALE_W;

	// registers and latched run settings
	logic [TARGET_W-1:0] tgt_cfg_q;
	logic [SCALE_W-1:0] scale_cfg_q;
	logic [GOOD_W-1:0] run_tgt_q;
	logic [SCALE_W-1:0] run_scale_q;
	logic [GOOD_W-1:0] step_q;
	logic prog_en_q;
	logic running_q;

	// run state
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic [GOOD_W-1:0] good_q;
	logic [ATT_W-1:0] att_q;
	logic [GOOD_W-1:0] pcnt_q;
	logic [ERR_W-1:0] lerr_q;

	// outcome of the last transfer
	logic prog_q;
	logic fin_q;
	status_t fin_status_q;

	logic signed [OFFSET_W-1:0] off_x_q, off_y_q, off_z_q;
	logic [DEN_W-1:0] den_q;

	// result register
	logic out_valid_q;
	kind_t out_kind_q;
	status_t out_status_q;
	logic [ERR_W-1:0] out_err_q;
	logic [TARGET_W-1:0] out_good_q;
	logic signed [OFFSET_W-1:0] out_x_q, out_y_q, out_z_q;
	logic out_last_q;

	logic take;
	logic is_start;
	logic args_ok;
	logic [TARGET_W-1:0] tgt_sat;
	logic [GOOD_W-1:0] good_inc, good_nx, pcnt_inc;
	logic [ATT_W-1:0] att_inc, att_lim;
	logic [GOOD_W:0] min_good;
	logic [ERR_W-1:0] lerr_nx;
	logic hit_prog, end_run;
	status_t end_status;

	logic signed [SUM_W-1:0] div_num;
	logic div_busy, div_done;
	logic signed [OFFSET_W-1:0] div_quot;

	assign cfg.ready = 1'b1;
	assign items.ready = cmd.in_ready;
	assign take = items.valid && cmd.in_ready;
	assign is_start = items.opcode == OP_START;

	assign args_ok = (tgt_cfg_q != '0) && (scale_cfg_q != '0);
	assign tgt_sat = (tgt_cfg_q > TARGET_W'(TGT_MAX)) ? TARGET_W'(TGT_MAX) : tgt_cfg_q;

	assign good_inc = good_q + 1'b1;
	assign att_inc = att_q + 1'b1;
	assign pcnt_inc = pcnt_q + 1'b1;
	assign good_nx = items.read_ok ? good_inc : good_q;
	assign lerr_nx = items.read_ok ? lerr_q : items.read_error;
	assign att_lim = ATT_W'(run_tgt_q) + ATT_W'(EXTRA_ATTEMPTS);
	assign min_good = ((GOOD_W + 1)'(run_tgt_q) + 1'b1) >> 1;
	assign hit_prog = items.read_ok && prog_en_q && (pcnt_inc >= step_q);
	assign end_run = (good_nx >= run_tgt_q) || (att_inc >= att_lim);

	always_comb begin
		if ({1'b0, good_nx} >= min_good)
			end_status = ST_OK;
		else if (lerr_nx != '0)
			end_status = ST_READ_ERR;
		else
			end_status = ST_FAIL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_cfg_q <= TARGET_RESET;
			scale_cfg_q <= SCALE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_TARGET: tgt_cfg_q <= cfg.data[TARGET_W-1:0];
				CFG_SCALE: scale_cfg_q <= cfg.data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			run_tgt_q <= '0;
			run_scale_q <= '0;
			step_q <= '0;
			prog_en_q <= 1'b0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			good_q <= '0;
			att_q <= '0;
			pcnt_q <= '0;
			lerr_q <= '0;
			prog_q <= 1'b0;
			fin_q <= 1'b0;
			fin_status_q <= ST_OK;
		end else if (take) begin
			prog_q <= 1'b0;
			fin_q <= 1'b0;
			if (is_start) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_z_q <= '0;
				good_q <= '0;
				att_q <= '0;
				pcnt_q <= '0;
				lerr_q <= '0;
				running_q <= args_ok;
				fin_q <= !args_ok;
				fin_status_q <= ST_INVALID;
				if (args_ok) begin
					run_tgt_q <= GOOD_W'(tgt_sat);
					run_scale_q <= scale_cfg_q;
					step_q <= GOOD_W'(div5(tgt_sat));
					prog_en_q <= tgt_sat >= TARGET_W'(5);
				end
			end else if (running_q) begin
				att_q <= att_inc;
				good_q <= good_nx;
				lerr_q <= lerr_nx;
				if (items.read_ok) begin
					sum_x_q <= sum_x_q + SUM_W'(items.raw_x);
					sum_y_q <= sum_y_q + SUM_W'(items.raw_y);
					sum_z_q <= sum_z_q + SUM_W'(items.raw_z);
					if (prog_en_q)
						pcnt_q <= hit_prog ? '0 : pcnt_inc;
				end
				prog_q <= hit_prog;
				fin_q <= end_run;
				fin_status_q <= end_status;
				if (end_run)
					running_q <= 1'b0;
			end
		end
	end

	// divisor is settled well before the controller starts a division
	always_ff @(posedge clk) begin
		den_q <= good_q * run_scale_q;
	end

	always_comb begin
		case (cmd.axis)
			AXIS_X: div_num = sum_x_q;
			AXIS_Y: div_num = sum_y_q;
			AXIS_Z: div_num = sum_z_q;
			default: div_num = sum_x_q;
		endcase
	end

	gbc_div #(
		.SUM_W(SUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num(div_num),
		.den(den_q),
		.busy(div_busy),
		.done(div_done),
		.quot(div_quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			case (cmd.axis)
				AXIS_X: off_x_q <= div_quot;
				AXIS_Y: off_y_q <= div_quot;
				AXIS_Z: off_z_q <= div_quot;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_prog || cmd.load_fin) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_prog) begin
			out_kind_q <= KIND_PROGRESS;
			out_status_q <= ST_OK;
			out_err_q <= '0;
			out_good_q <= TARGET_W'(good_q);
			out_x_q <= '0;
			out_y_q <= '0;
			out_z_q <= '0;
			out_last_q <= !fin_q;
		end else if (cmd.load_fin) begin
			out_kind_q <= KIND_DONE;
			out_status_q <= fin_status_q;
			out_err_q <= (fin_status_q == ST_READ_ERR) ? lerr_q : '0;
			out_good_q <= TARGET_W'(good_q);
			out_x_q <= (fin_status_q == ST_OK) ? off_x_q : '0;
			out_y_q <= (fin_status_q == ST_OK) ? off_y_q : '0;
			out_z_q <= (fin_status_q == ST_OK) ? off_z_q : '0;
			out_last_q <= 1'b1;
		end
	end

	assign results.valid = out_valid_q;
	assign results.kind = out_kind_q;
	assign results.status = out_status_q;
	assign results.error_code = out_err_q;
	assign results.good_count = out_good_q;
	assign results.offset_x = out_x_q;
	assign results.offset_y = out_y_q;
	assign results.offset_z = out_z_q;
	assign results.last_result = out_last_q;

	assign sts.in_valid = items.valid;
	assign sts.prog = prog_q;
	assign sts.fin = fin_q;
	assign sts.need_div = fin_q && (fin_status_q == ST_OK);
	assign sts.out_busy = out_valid_q && !results.ready;
	assign sts.div_done = div_done;

	a_no_take_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !div_busy)
		else $error("item transfer while divider busy");

	a_good_below_target: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> good_q < run_tgt_q)
		else $error("run still open with target reached");

	a_attempts_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> att_q < att_lim)
		else $error("run still open past attempt limit");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.kind == KIND_DONE) |-> results.last_result)
		else $error("finished result not marked last");

endmodule

FILE: hw/rtl/gbc_ctrl.sv
// controller sequencing result emission and the per-axis divisions
module gbc_ctrl (
	input logic clk,
	input logic arst_n,
	input gbc_pkg::gbc_sts_t sts,
	output gbc_pkg::gbc_cmd_t cmd
);
	import gbc_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EVAL = 6'b000010,
		S_PROG = 6'b000100,
		S_DGO = 6'b001000,
		S_DWAIT = 6'b010000,
		S_FIN = 6'b100000
	} state_t;

	state_t state_q, state_nx;
	axis_t axis_q, axis_nx;

	always_comb begin
		state_nx = state_q;
		axis_nx = axis_q;
		cmd = '0;
		cmd.axis = axis_q;
		case (state_q)
			S_IDLE: begin
				// idle only moves on when an item transfer actually happens
				cmd.in_ready = 1'b1;
				if (sts.in_valid)
					state_nx = S_EVAL;
			end
			S_EVAL: begin
				axis_nx = AXIS_X;
				if (sts.prog)
					state_nx = S_PROG;
				else if (sts.fin)
					state_nx = sts.need_div ? S_DGO : S_FIN;
				else
					state_nx = S_IDLE;
			end
			S_PROG: begin
				if (!sts.out_busy) begin
					cmd.load_prog = 1'b1;
					if (sts.fin)
						state_nx = sts.need_div ? S_DGO : S_FIN;
					else
						state_nx = S_IDLE;
				end
			end
			S_DGO: begin
				cmd.div_start = 1'b1;
				state_nx = S_DWAIT;
			end
			S_DWAIT: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					if (axis_q == AXIS_Z) begin
						state_nx = S_FIN;
					end else begin
						axis_nx = axis_t'(axis_q + 2'd1);
						state_nx = S_DGO;
					end
				end
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.load_fin = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= AXIS_X;
		end else begin
			axis_q <= axis_nx;
			state_q <= state_nx;
		end
	end

endmodule

FILE: hw/rtl/gyro_bias_calibrator.sv
// gyro bias calibrator top level
//
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------------------
//  items    | in  | opcode, read_ok, read_error, raw_x, raw_y, raw_z
//  results  | out | kind, status, error_code, good_count, offset_x/y/z, last_result
//  cfg      | in  | index (0 target_samples, 1 scale_lsb_per_dps), data
//
// one item at a time: a start or a sample is evaluated before the next item is taken,
// and each result is loaded into the result register; a successful end also runs the
// shared bit-serial divider once per axis, with SUM_W = clog2(target max) + 17.
// arst_n clears the run state and loads the register reset values.
// items keep flowing while a result waits; a stalled result only holds the
// block once the next result is due, until the result register frees up.
module gyro_bias_calibrator #(
	parameter int MAX_SAMPLES = gbc_pkg::MAX_SAMPLES_DEF,
	parameter int EXTRA_ATTEMPTS = gbc_pkg::EXTRA_ATTEMPTS_DEF
) (
	input logic clk,
	input logic arst_n,
	gbc_in_if.sink items,
	gbc_out_if.source results,
	gbc_cfg_if.sink cfg
);
	import gbc_pkg::*;

	gbc_cmd_t cmd;
	gbc_sts_t sts;

	gbc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sts(sts),
		.cmd(cmd)
	);

	gbc_datapath #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.EXTRA_ATTEMPTS(EXTRA_ATTEMPTS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.results(results),
		.cfg(cfg),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// testbench for the gyro bias calibrator: directed and random calibration runs against a predictor
import gbc_pkg::*;

typedef struct packed {
	opcode_t opcode;
	logic read_ok;
	logic [ERR_W-1:0] read_error;
	logic signed [RAW_W-1:0] raw_x;
	logic signed [RAW_W-1:0] raw_y;
	logic signed [RAW_W-1:0] raw_z;
} gyro_read_t;

typedef struct packed {
	kind_t kind;
	status_t status;
	logic [ERR_W-1:0] error_code;
	logic [TARGET_W-1:0] good_count;
	logic signed [OFFSET_W-1:0] offset_x;
	logic signed [OFFSET_W-1:0] offset_y;
	logic signed [OFFSET_W-1:0] offset_z;
	logic last_result;
} cal_report_t;

class bias_cal_model;
	logic [TARGET_W-1:0] target_reg;
	logic [SCALE_W-1:0] scale_reg;
	logic signed [29:0] sum_x;
	logic signed [29:0] sum_y;
	logic signed [29:0] sum_z;
	logic [TARGET_W-1:0] good_samples;
	logic [TARGET_W-1:0] attempts;
	logic [TARGET_W-1:0] progress_cnt;
	logic [TARGET_W-1:0] run_target;
	logic [SCALE_W-1:0] run_scale;
	logic [ERR_W-1:0] last_error;
	bit running;
	cal_report_t expected_reports[$];
	int errors;
	int reports_seen;

	function new();
		target_reg = TARGET_RESET;
		scale_reg = SCALE_RESET;
		clear_run();
		running = 1'b0;
		run_target = '0;
		run_scale = '0;
		errors = 0;
		reports_seen = 0;
	endfunction

	function void clear_run();
		sum_x = '0;
		sum_y = '0;
		sum_z = '0;
		good_samples = '0;
		attempts = '0;
		progress_cnt = '0;
		last_error = '0;
	endfunction

	function void flag(string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch: %s", msg);
	endfunction

	function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_TARGET: target_reg = data[TARGET_W-1:0];
			CFG_SCALE: scale_reg = data;
			default: ;
		endcase
	endfunction

	// mean of the sum in deg/s, Q15.16, truncated toward zero and saturated
	function logic signed [OFFSET_W-1:0] mean_bias(logic signed [29:0] sum);
		longint den;
		longint q;
		den = longint'(good_samples) * longint'(run_scale);
		if (den <= 0)
			return '0;
		q = (longint'(sum) * (64'sd1 <<< OFFSET_SHIFT)) / den;
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return OFFSET_W'(q);
	endfunction

	function cal_report_t make_report(kind_t kind, status_t status, logic [ERR_W-1:0] err,
		logic signed [OFFSET_W-1:0] ox, logic signed [OFFSET_W-1:0] oy,
		logic signed [OFFSET_W-1:0] oz);
		cal_report_t r;
		r.kind = kind;
		r.status = status;
		r.error_code = err;
		r.good_count = good_samples;
		r.offset_x = ox;
		r.offset_y = oy;
		r.offset_z = oz;
		r.last_result = 1'b0;
		return r;
	endfunction

	function void take_read(gyro_read_t rd);
		cal_report_t step_reports[$];
		cal_report_t tail;
		int unsigned floor_good;
		if (rd.opcode == OP_START) begin
			clear_run();
			running = 1'b0;
			if (target_reg == 0 || scale_reg == 0) begin
				step_reports.push_back(make_report(KIND_DONE, ST_INVALID, '0, '0, '0, '0));
			end else begin
				run_target = (target_reg > MAX_SAMPLES_DEF) ? TARGET_W'(MAX_SAMPLES_DEF) :
					target_reg;
				run_scale = scale_reg;
				running = 1'b1;
			end
		end else if (running) begin
			attempts++;
			if (rd.read_ok) begin
				sum_x += $signed(rd.raw_x);
				sum_y += $signed(rd.raw_y);
				sum_z += $signed(rd.raw_z);
				good_samples++;
				if (run_target >= 5) begin
					progress_cnt++;
					if (progress_cnt >= run_target / 5) begin
						progress_cnt = '0;
						step_reports.push_back(make_report(KIND_PROGRESS, ST_OK, '0, '0, '0, '0));
					end
				end
			end else begin
				last_error = rd.read_error;
			end
			if (good_samples >= run_target || attempts >= run_target + EXTRA_ATTEMPTS_DEF) begin
				running = 1'b0;
				floor_good = (run_target + 1) / 2;
				if (floor_good < 1)
					floor_good = 1;
				if (good_samples < floor_good) begin
					if (last_error != 0)
						step_reports.push_back(make_report(KIND_DONE, ST_READ_ERR, last_error,
							'0, '0, '0));
					else
						step_reports.push_back(make_report(KIND_DONE, ST_FAIL, '0, '0, '0, '0));
				end else begin
					step_reports.push_back(make_report(KIND_DONE, ST_OK, '0, mean_bias(sum_x),
						mean_bias(sum_y), mean_bias(sum_z)));
				end
			end
		end
		if (step_reports.size() > 0) begin
			tail = step_reports.pop_back();
			tail.last_result = 1'b1;
			step_reports.push_back(tail);
		end
		foreach (step_reports[i])
			expected_reports.push_back(step_reports[i]);
	endfunction

	function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got)
			flag($sformatf("report %0d %s: expected %0h, got %0h", reports_seen, name, want, got));
	endfunction

	function void check_report(cal_report_t got);
		cal_report_t want;
		reports_seen++;
		if (expected_reports.size() == 0) begin
			flag($sformatf("report %0d arrived with none expected", reports_seen));
			return;
		end
		want = expected_reports.pop_front();
		cmp_field("kind", want.kind, got.kind);
		cmp_field("status", want.status, got.status);
		cmp_field("error_code", want.error_code, got.error_code);
		cmp_field("good_count", want.good_count, got.good_count);
		cmp_field("offset_x", want.offset_x, got.offset_x);
		cmp_field("offset_y", want.offset_y, got.offset_y);
		cmp_field("offset_z", want.offset_z, got.offset_z);
		cmp_field("last_result", want.last_result, got.last_result);
	endfunction
endclass

module tb_top;
	localparam int RANDOM_ITEMS = 1550;
	localparam int SETTLE_CYCLES = 20;
	localparam int TAIL_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n;
	bit quiet;
	bit run_open;
	int random_items;
	int phase;
	logic [TARGET_W-1:0] cur_target;
	logic [SCALE_W-1:0] cur_scale;
	bias_cal_model cal = new();

	gbc_in_if items_ch();
	gbc_out_if results_ch();
	gbc_cfg_if cfg_ch();

	gyro_bias_calibrator #(
		.MAX_SAMPLES(MAX_SAMPLES_DEF),
		.EXTRA_ATTEMPTS(EXTRA_ATTEMPTS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch),
		.cfg(cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin : watch
		gyro_read_t rd;
		cal_report_t rep;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				cal.write_reg(cfg_idx_t'(cfg_ch.index), cfg_ch.data);
			if (items_ch.valid && items_ch.ready) begin
				rd.opcode = opcode_t'(items_ch.opcode);
				rd.read_ok = items_ch.read_ok;
				rd.read_error = items_ch.read_error;
				rd.raw_x = items_ch.raw_x;
				rd.raw_y = items_ch.raw_y;
				rd.raw_z = items_ch.raw_z;
				cal.take_read(rd);
			end
			if (results_ch.valid && results_ch.ready) begin
				rep.kind = kind_t'(results_ch.kind);
				rep.status = status_t'(results_ch.status);
				rep.error_code = results_ch.error_code;
				rep.good_count = results_ch.good_count;
				rep.offset_x = results_ch.offset_x;
				rep.offset_y = results_ch.offset_y;
				rep.offset_z = results_ch.offset_z;
				rep.last_result = results_ch.last_result;
				cal.check_report(rep);
			end
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ERR_W-1:0] rand_err();
		if ($urandom_range(0, 7) == 0)
			return '0;
		return ERR_W'($urandom_range(1, 255));
	endfunction

	function automatic logic signed [RAW_W-1:0] rand_raw();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		if (r < 6)
			return RAW_W'(int'($urandom_range(0, 1000)) - 500);
		return RAW_W'($urandom);
	endfunction

	function automatic logic [TARGET_W-1:0] pick_target();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 35)
			return TARGET_W'($urandom_range(1, 4));
		if (r < 85)
			return TARGET_W'($urandom_range(5, 25));
		return TARGET_W'($urandom_range(26, 60));
	endfunction

	function automatic logic [SCALE_W-1:0] pick_scale();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 30)
			return SCALE_W'($urandom_range(1, 16));
		if (r < 40)
			return 16'hffff;
		if (r < 70)
			return SCALE_W'($urandom_range(200, 600));
		return SCALE_W'($urandom);
	endfunction

	// valid stays high from one transfer to the next unless a gap is drawn
	task automatic send_read(opcode_t op, logic ok, logic [ERR_W-1:0] err,
		logic signed [RAW_W-1:0] x, logic signed [RAW_W-1:0] y, logic signed [RAW_W-1:0] z);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.opcode <= op;
		items_ch.read_ok <= ok;
		items_ch.read_error <= err;
		items_ch.raw_x <= x;
		items_ch.raw_y <= y;
		items_ch.raw_z <= z;
		@(posedge clk);
		while (!items_ch.ready) @(posedge clk);
	endtask

	task automatic send_start();
		send_read(OP_START, 1'($urandom), rand_err(), rand_raw(), rand_raw(), rand_raw());
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		if (idx == CFG_TARGET)
			cur_target = data[TARGET_W-1:0];
		else
			cur_scale = data;
	endtask

	// upper data bits of the target write are don't-care
	task automatic set_regs(logic [TARGET_W-1:0] target, logic [SCALE_W-1:0] scale);
		write_reg(CFG_TARGET, {3'($urandom), target});
		write_reg(CFG_SCALE, scale);
		cfg_ch.valid <= 1'b0;
	endtask

	// hold off items until every report is in and the block has gone quiet
	task automatic settle();
		items_ch.valid <= 1'b0;
		@(posedge clk);
		while (cal.expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one run on the current registers; cut >= 0 abandons it after that many attempts
	task automatic calibrate(int ok_pct, int cut);
		int span;
		int good;
		int tries;
		logic ok;
		send_start();
		random_items++;
		if (cur_target == 0 || cur_scale == 0)
			span = 0;
		else
			span = (cur_target > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : cur_target;
		run_open = (span != 0);
		good = 0;
		tries = 0;
		while (run_open && good < span && tries < span + EXTRA_ATTEMPTS_DEF) begin
			if (tries == cut)
				return;
			ok = ($urandom_range(0, 99) < ok_pct);
			send_read(OP_SAMPLE, ok, rand_err(), rand_raw(), rand_raw(), rand_raw());
			random_items++;
			tries++;
			if (ok)
				good++;
		end
		run_open = 1'b0;
	endtask

	initial begin
		int n;
		results_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			n = $urandom_range(1, 20);
			results_ch.ready <= 1'b1;
			repeat (n) @(posedge clk);
			n = gap_len();
			if (n > 0) begin
				results_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		#50ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int r;
		arst_n <= 1'b0;
		items_ch.valid <= 1'b0;
		items_ch.opcode <= OP_START;
		items_ch.read_ok <= 1'b0;
		items_ch.read_error <= '0;
		items_ch.raw_x <= '0;
		items_ch.raw_y <= '0;
		items_ch.raw_z <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_TARGET;
		cfg_ch.data <= '0;
		cur_target = TARGET_RESET;
		cur_scale = SCALE_RESET;
		quiet = 1'b0;
		run_open = 1'b0;
		random_items = 0;
		phase = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sample while idle is dropped
		send_read(OP_SAMPLE, 1'b1, 8'hff, 16'sh7fff, 16'sh8000, 16'sh7fff);
		// run on the reset registers, abandoned by the next start
		send_read(OP_START, 1'b0, 8'h00, 0, 0, 0);
		send_read(OP_SAMPLE, 1'b1, 8'h00, 100, 200, 300);
		send_read(OP_SAMPLE, 1'b0, 8'h33, 0, 0, 0);
		settle();
		// short run, scale keeps its reset value
		write_reg(CFG_TARGET, 16'd3);
		cfg_ch.valid <= 1'b0;
		send_read(OP_START, 1'b1, 8'hff, -1, -1, -1);
		send_read(OP_SAMPLE, 1'b1, 8'h00, 1000, -2000, 32767);
		send_read(OP_SAMPLE, 1'b1, 8'h00, -1, 0, 32767);
		send_read(OP_SAMPLE, 1'b1, 8'h00, 7, 8, 32767);
		settle();
		// zero target, then zero scale
		set_regs(13'd0, 16'd256);
		send_start();
		settle();
		set_regs(13'd5, 16'd0);
		send_start();
		settle();
		// progress on every sample, progress and end together, saturated offsets
		set_regs(13'd5, 16'd1);
		send_start();
		repeat (5) send_read(OP_SAMPLE, 1'b1, 8'h00, 16'sh7fff, 16'sh8000, 0);
		settle();
		set_regs(13'd3, 16'hffff);
		send_start();
		send_read(OP_SAMPLE, 1'b1, 8'h00, -1, 1, 0);
		settle();
		// registers change mid-run: the run keeps target 3 and full scale
		set_regs(13'd8, 16'd2);
		send_read(OP_SAMPLE, 1'b1, 8'h00, 16'sh8000, 16'sh7fff, -1);
		send_read(OP_SAMPLE, 1'b1, 8'h00, 16'sh8000, 16'sh7fff, -1);
		// start while running
		send_start();
		send_read(OP_SAMPLE, 1'b1, 8'h00, 5, 6, 7);
		send_start();
		settle();

		// nothing but failed reads: last code zero gives fail, nonzero gives read error
		set_regs(13'd2, SCALE_RESET);
		for (int k = 0; k < 2; k++) begin
			send_start();
			repeat (EXTRA_ATTEMPTS_DEF + 1)
				send_read(OP_SAMPLE, 1'b0, rand_err(), rand_raw(), rand_raw(), rand_raw());
			send_read(OP_SAMPLE, 1'b0, k ? 8'ha5 : 8'h00, rand_raw(), rand_raw(), rand_raw());
			random_items += EXTRA_ATTEMPTS_DEF + 3;
		end

		while (random_items < RANDOM_ITEMS) begin
			phase++;
			settle();
			quiet = ($urandom_range(0, 5) == 0);
			if (phase == 3) begin
				// largest target saturates: first progress report lands at 4096 / 5
				set_regs(TARGET_W'(TARGET_CFG_MAX), SCALE_W'($urandom_range(1, 65535)));
				calibrate(100, 830);
			end else begin
				set_regs(pick_target(), pick_scale());
				repeat ($urandom_range(1, 4)) begin
					if (!run_open)
						repeat ($urandom_range(0, 2))
							send_read(OP_SAMPLE, 1'($urandom), rand_err(), rand_raw(), rand_raw(),
								rand_raw());
					r = $urandom_range(0, 99);
					if (r < 12)
						calibrate($urandom_range(70, 100), $urandom_range(0, 10));
					else if (r < 24 && cur_target <= 12)
						calibrate($urandom_range(0, 20), -1);
					else
						calibrate($urandom_range(70, 100), -1);
				end
			end
		end

		quiet = 1'b0;
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (cal.expected_reports.size() != 0)
			cal.flag($sformatf("%0d reports never arrived", cal.expected_reports.size()));
		if (cal.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
